// ===== rtl/assert_macros.svh =====
// assertion macros used by the deadline timeout scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, checked only out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication, checked only out of reset
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== rtl/dts_pkg.sv =====
// constants and types of the deadline timeout scheduler
package dts_pkg;

    localparam int NUM_TASKS = 16;
    localparam int TIME_BITS = 48;
    localparam int MAX_OUT   = 16;

    localparam int IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int ADDR_W = $clog2(NUM_TASKS + 1);
    localparam int CNT_W  = $clog2(MAX_OUT + 1);

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [2:0] ST_ARMED     = 3'd0;
    localparam logic [2:0] ST_IGNORED   = 3'd1;
    localparam logic [2:0] ST_CANCELLED = 3'd2;
    localparam logic [2:0] ST_CANCEL_NO = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_QUIET     = 3'd5;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

endpackage

// ===== rtl/deadline_timeout_scheduler.sv =====
// deadline timeout scheduler: deadline memory with repeated expiry scans
//
//  channel | direction | valid / ready             | payload
//  in      | input     | i_in_valid / o_in_ready   | i_opcode, i_task_id, i_delay_ms
//  out     | output    | o_out_valid / i_out_ready | o_status, o_task_id_out, o_last
//
// arm and cancel each give one result; unused opcode three gives no result.
// a tick runs scan rounds over the deadline memory, one read per cycle; each round
// picks the earliest expired task. k expiries below MAX_OUT need k + 1 rounds,
// and MAX_OUT expiries need MAX_OUT rounds.
// synchronous active-low reset clears pending bits, time and control; memory is not cleared.
// a stalled output holds the scan at the end of its round until the result slot frees.
`include "assert_macros.svh"

module deadline_timeout_scheduler import dts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_task_id,
    input  logic [31:0] i_delay_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_task_id_out,
    output logic        o_last
);

    localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(NUM_TASKS);
    localparam t_time             TIME_MAX = '1;

    t_time             r_mem [NUM_TASKS];
    t_state            r_state;
    logic [NUM_TASKS-1:0] r_pending;
    t_time             r_now;
    logic              r_o_valid;
    logic [2:0]        r_o_status;
    logic [3:0]        r_o_id;
    logic              r_o_last;
    logic [ADDR_W-1:0] r_addr;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    t_time             r_rd_data;
    logic              r_have_best;
    t_time             r_best_dl;
    logic [IDX_W-1:0]  r_best_idx;
    logic              r_held_v;
    logic [IDX_W-1:0]  r_held_idx;
    logic [CNT_W-1:0]  r_cnt;

    logic              out_free;
    logic              in_xfer;
    logic              id_ok;
    logic [IDX_W-1:0]  id_idx;
    logic [TIME_BITS:0] arm_sum;
    t_time             n_deadline;
    t_time             n_now;
    logic              rd_en;
    logic              round_done;
    logic              better;
    logic              arm_wr;

    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign id_ok      = 32'(i_task_id) < 32'(NUM_TASKS);
    assign id_idx     = IDX_W'(i_task_id);

    assign arm_sum    = {1'b0, r_now} + (TIME_BITS + 1)'(i_delay_ms);
    assign n_deadline = arm_sum[TIME_BITS] ? TIME_MAX : arm_sum[TIME_BITS-1:0];
    assign n_now      = (r_now == TIME_MAX) ? TIME_MAX : r_now + TIME_BITS'(1);

    assign arm_wr     = in_xfer && (i_opcode == OP_ARM) && id_ok && !r_pending[id_idx];
    assign rd_en      = (r_state == S_SCAN) && (r_addr != ADDR_END);
    assign round_done = (r_addr == ADDR_END) && !r_rd_vld;
    assign better     = r_rd_vld && r_pending[r_rd_idx] && (r_rd_data <= r_now)
                        && (!r_have_best || (r_rd_data < r_best_dl));

    always_ff @(posedge i_clk) begin
        if (arm_wr) begin
            r_mem[id_idx] <= n_deadline;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pending   <= '0;
            r_now       <= '0;
            r_o_valid   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_held_v    <= 1'b0;
            r_addr      <= '0;
            r_cnt       <= '0;
        end else begin
            if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            r_rd_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        case (i_opcode)
                            OP_ARM: begin
                                r_o_valid <= 1'b1;
                                r_o_last  <= 1'b1;
                                r_o_id    <= i_task_id;
                                if (!id_ok || r_pending[id_idx]) begin
                                    r_o_status <= ST_IGNORED;
                                end else begin
                                    r_o_status         <= ST_ARMED;
                                    r_pending[id_idx]  <= 1'b1;
                                end
                            end
                            OP_CANCEL: begin
                                r_o_valid <= 1'b1;
                                r_o_last  <= 1'b1;
                                r_o_id    <= i_task_id;
                                if (id_ok && r_pending[id_idx]) begin
                                    r_o_status        <= ST_CANCELLED;
                                    r_pending[id_idx] <= 1'b0;
                                end else begin
                                    r_o_status <= ST_CANCEL_NO;
                                end
                            end
                            OP_TICK: begin
                                r_now       <= n_now;
                                r_state     <= S_SCAN;
                                r_addr      <= '0;
                                r_have_best <= 1'b0;
                                r_held_v    <= 1'b0;
                                r_cnt       <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_addr[IDX_W-1:0];
                        r_addr   <= r_addr + ADDR_W'(1);
                    end
                    if (better) begin
                        r_have_best <= 1'b1;
                        r_best_dl   <= r_rd_data;
                        r_best_idx  <= r_rd_idx;
                    end
                    if (round_done) begin
                        if (r_have_best) begin
                            if (!r_held_v || out_free) begin
                                r_pending[r_best_idx] <= 1'b0;
                                if (r_held_v) begin
                                    r_o_valid  <= 1'b1;
                                    r_o_status <= ST_EXPIRED;
                                    r_o_id     <= 4'(r_held_idx);
                                    r_o_last   <= 1'b0;
                                end
                                r_held_v    <= 1'b1;
                                r_held_idx  <= r_best_idx;
                                r_have_best <= 1'b0;
                                r_cnt       <= r_cnt + CNT_W'(1);
                                r_addr      <= (r_cnt == CNT_W'(MAX_OUT - 1)) ? ADDR_END : '0;
                            end
                        end else if (out_free) begin
                            r_o_valid <= 1'b1;
                            r_o_last  <= 1'b1;
                            if (r_held_v) begin
                                r_o_status <= ST_EXPIRED;
                                r_o_id     <= 4'(r_held_idx);
                            end else begin
                                r_o_status <= ST_QUIET;
                                r_o_id     <= 4'd0;
                            end
                            r_held_v <= 1'b0;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_task_id_out = r_o_id;
    assign o_last        = r_o_last;

    `ASSERT_IMPL(a_no_accept_in_scan, i_clk, i_rst_n, r_state == S_SCAN, !o_in_ready,
        "input accepted during expiry scan")
    `ASSERT_IMPL(a_held_only_in_scan, i_clk, i_rst_n, r_held_v, r_state == S_SCAN,
        "held expiry outside a scan")
    `ASSERT_IMPL(a_nonlast_in_scan, i_clk, i_rst_n, r_o_valid && !r_o_last,
        r_state == S_SCAN, "non-final result left pending after the scan")
    `ASSERT_CLK(a_time_only_on_tick, i_clk, i_rst_n,
        !(in_xfer && (i_opcode == OP_TICK)) |=> $stable(r_now),
        "time changed without a tick")

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the deadline timeout scheduler
`timescale 1ns / 1ps

module tb_top;
    import dts_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam t_time TIME_MAX = '1;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] task_id;
        logic       last;
    } t_report;

    class timeout_scoreboard;
        bit      armed [NUM_TASKS];
        t_time   due_at [NUM_TASKS];
        t_time   now_ms;
        t_report awaited[$];
        int      errors;
        int      n_arm, n_cancel, n_tick, n_expired, n_quiet;

        function new();
            armed  = '{default: 1'b0};
            now_ms = '0;
        endfunction

        function t_time add_sat(t_time base, logic [31:0] delta);
            logic [TIME_BITS:0] sum;
            sum = {1'b0, base} + (TIME_BITS + 1)'(delta);
            if (sum > {1'b0, TIME_MAX})
                return TIME_MAX;
            return sum[TIME_BITS-1:0];
        endfunction

        function void push(logic [2:0] status, logic [3:0] id, logic last);
            t_report r;
            r.status  = status;
            r.task_id = id;
            r.last    = last;
            awaited.push_back(r);
        endfunction

        function void note_request(logic [1:0] op, logic [3:0] id, logic [31:0] delay);
            int best;
            int fired;
            bit searching;
            case (op)
                OP_ARM: begin
                    n_arm++;
                    if (32'(id) >= 32'(NUM_TASKS) || armed[id]) begin
                        push(ST_IGNORED, id, 1'b1);
                    end else begin
                        due_at[id] = add_sat(now_ms, delay);
                        armed[id]  = 1'b1;
                        push(ST_ARMED, id, 1'b1);
                    end
                end
                OP_CANCEL: begin
                    n_cancel++;
                    if (32'(id) < 32'(NUM_TASKS) && armed[id]) begin
                        armed[id] = 1'b0;
                        push(ST_CANCELLED, id, 1'b1);
                    end else begin
                        push(ST_CANCEL_NO, id, 1'b1);
                    end
                end
                OP_TICK: begin
                    n_tick++;
                    now_ms = add_sat(now_ms, 32'd1);
                    fired = 0;
                    searching = 1'b1;
                    while (searching && fired < MAX_OUT) begin
                        best = -1;
                        for (int t = 0; t < NUM_TASKS; t++) begin
                            if (armed[t[IDX_W-1:0]] && due_at[t[IDX_W-1:0]] <= now_ms &&
                                (best < 0 ||
                                 due_at[t[IDX_W-1:0]] < due_at[best[IDX_W-1:0]]))
                                best = t;
                        end
                        if (best < 0) begin
                            searching = 1'b0;
                        end else begin
                            armed[best[IDX_W-1:0]] = 1'b0;
                            push(ST_EXPIRED, best[3:0], 1'b0);
                            fired++;
                        end
                    end
                    if (fired == 0)
                        push(ST_QUIET, 4'd0, 1'b1);
                    else
                        awaited[awaited.size()-1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_response(logic [2:0] status, logic [3:0] id, logic last);
            t_report want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %0d task %0d last %0d",
                         $time, "actual status", status, id, last);
                return;
            end
            want = awaited.pop_front();
            if (want.status == ST_EXPIRED)
                n_expired++;
            if (want.status == ST_QUIET)
                n_quiet++;
            if (status !== want.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            end
            if (id !== want.task_id) begin
                errors++;
                $display("%0t: task id expected %0d actual %0d", $time, want.task_id, id);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = OP_ARM;
    logic [3:0]  i_task_id = '0;
    logic [31:0] i_delay_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [3:0]  o_task_id_out;
    logic        o_last;

    timeout_scoreboard board = new();
    bit gapless = 1'b0;
    int requests_sent = 0;

    deadline_timeout_scheduler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_task_id     (i_task_id),
        .i_delay_ms    (i_delay_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_task_id_out (o_task_id_out),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_response(o_status, o_task_id_out, o_last);
        i_out_ready <= gapless || ($urandom_range(0, 99) >= 26);
    end

    task automatic send_request(input logic [1:0] op, input logic [3:0] id,
                                input logic [31:0] delay);
        while (!gapless && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_task_id  <= id;
        i_delay_ms <= delay;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(op, id, delay);
        if (op != OP_UNUSED)
            requests_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 8);
        if (r < 95)
            return $urandom_range(9, 60);
        return $urandom;
    endfunction

    initial begin
        int r;
        int base;
        bit drained_mid;
        logic [1:0] op;
        drained_mid = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // quiet tick, idle cancel, arm at delay zero, arm while pending, longest delay
        send_request(OP_TICK, 4'd0, 32'd0);
        send_request(OP_CANCEL, 4'd5, 32'd0);
        send_request(OP_ARM, 4'd0, 32'd0);
        send_request(OP_ARM, 4'd0, 32'd7);
        send_request(OP_ARM, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 4'd10, 32'hA5A5_5A5A);
        send_request(OP_CANCEL, 4'd15, 32'd0);
        send_request(OP_TICK, 4'd0, 32'd0);
        // every task at once: deadline order first, then lower id on ties
        for (int t = NUM_TASKS - 1; t >= 0; t--)
            send_request(OP_ARM, t[3:0], (t >= 8) ? 32'd0 : 32'd1);
        send_request(OP_TICK, 4'd0, 32'd0);
        drain_results();

        requests_sent = 0;
        while (requests_sent < 330) begin
            gapless = (requests_sent >= 150 && requests_sent < 200);
            if (!drained_mid && requests_sent >= 250) begin
                drain_results();
                drained_mid = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                base = $urandom_range(0, NUM_TASKS - 1);
                for (int k = 0; k < NUM_TASKS; k++)
                    send_request(OP_ARM, 4'((base + k) % NUM_TASKS), $urandom_range(0, 2));
                repeat (3) send_request(OP_TICK, 4'($urandom), $urandom);
            end else if (r < 9) begin
                for (int k = 0; k < NUM_TASKS; k++)
                    send_request(OP_CANCEL, k[3:0], $urandom);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    op = OP_ARM;
                else if (r < 60)
                    op = OP_CANCEL;
                else if (r < 95)
                    op = OP_TICK;
                else
                    op = OP_UNUSED;
                send_request(op, 4'($urandom), (op == OP_ARM) ? pick_delay() : $urandom);
            end
        end
        gapless = 1'b0;
        drain_results();
        repeat (400) @(posedge i_clk);

        $display("ran %0d arms, %0d cancels and %0d ticks", board.n_arm, board.n_cancel,
                 board.n_tick);
        $display("saw %0d expiries and %0d quiet ticks, %0d mismatches", board.n_expired,
                 board.n_quiet, board.errors);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #8_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
